// ----- sv/spfl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfl_pkg: shared types and constants of the slot pool allocator
// Field widths, request and status codes, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package spfl_pkg;

    // Payload field widths
    localparam int OP_W     = 1;
    localparam int SLOT_W   = 6;
    localparam int HANDLE_W = 6;
    localparam int STATUS_W = 1;

    // Request codes
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 1'b0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic start;   // capture request, issue link read
        logic link;    // first link update phase
        logic finish;  // last link update, load result
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic no_work; // request needs no link update (pool full or ignored free)
    } flags_t;

endpackage

// ----- sv/spfl_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfl_if: request and result channels of the slot pool allocator
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface spfl_req_if;
    logic                          valid;
    logic                          ready;
    logic [spfl_pkg::OP_W-1:0]     operation;
    logic [spfl_pkg::SLOT_W-1:0]   slot_index;

    modport source (output valid, operation, slot_index, input ready);
    modport sink   (input valid, operation, slot_index, output ready);
endinterface

interface spfl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [spfl_pkg::HANDLE_W-1:0] handle;
    logic [spfl_pkg::STATUS_W-1:0] status;

    modport source (output valid, handle, status, input ready);
    modport sink   (input valid, handle, status, output ready);
endinterface

// ----- sv/spfl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfl_ctrl: request sequencer of the slot pool allocator
// Steps each request through capture, link update and result load, and
// holds the result valid flag until the result is taken.
// ----------------------------------------------------------------------------
module spfl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  spfl_pkg::flags_t flags,
    output spfl_pkg::cmd_t   cmd
);

    typedef enum logic [1:0] {
        IDLE,
        READ,
        WRITE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // Result register can take a new result this cycle
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == IDLE);
    assign out_valid = out_valid_reg;

    // Sequence one request
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = READ;
                end
            end
            READ:
            begin
                if (flags.no_work)
                begin
                    if (out_free)
                    begin
                        cmd.finish     = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = IDLE;
                    end
                    else
                    begin
                        state_next = WRITE;
                    end
                end
                else
                begin
                    cmd.link   = 1'b1;
                    state_next = WRITE;
                end
            end
            WRITE:
            begin
                // Hold here until the result register frees up
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // State and result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Commands are mutually exclusive
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.link, cmd.finish}))
        else $error("more than one datapath command in a cycle");

    // A captured request either updates links or has nothing to update
    a_start_then_link: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (cmd.link != flags.no_work))
        else $error("link phase does not follow capture");

    // A loaded result is shown as valid
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("result loaded without valid");

endmodule

// ----- sv/spfl_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfl_datapath: link memories and list heads of the slot pool allocator
// Holds the next and prev link memories, the free and in-use list heads and
// the bump counter, and applies the link updates the controller steps through.
// ----------------------------------------------------------------------------
module spfl_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spfl_pkg::cmd_t                cmd,
    output spfl_pkg::flags_t              flags,
    input  logic [spfl_pkg::OP_W-1:0]     operation,
    input  logic [spfl_pkg::SLOT_W-1:0]   slot_index,
    output logic [spfl_pkg::HANDLE_W-1:0] handle,
    output logic [spfl_pkg::STATUS_W-1:0] status
);

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int SW = spfl_pkg::SLOT_W;
    localparam int HW = spfl_pkg::HANDLE_W;
    localparam int CW = (LW > SW) ? LW : SW;
    localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);

    // Link memories
    logic [LW-1:0] next_mem [CAPACITY];
    logic [LW-1:0] prev_mem [CAPACITY];

    // List heads and bump counter
    logic [LW-1:0] active_head_reg;
    logic [LW-1:0] free_head_reg;
    logic [LW-1:0] used_count_reg;

    // Captured request
    logic                  op_reg;
    logic [IW-1:0]         slot_reg;
    logic                  go_reg;
    logic                  from_free_reg;
    logic                  full_reg;
    logic [LW-1:0]         aux_reg;
    logic [LW-1:0]         next_rd_reg;
    logic [LW-1:0]         prev_rd_reg;
    logic [HW-1:0]         handle_reg;
    logic [spfl_pkg::STATUS_W-1:0] status_reg;

    // Request decode
    logic          is_free;
    logic          free_avail;
    logic          bump_avail;
    logic          idx_ok;
    logic          start_go;
    logic [IW-1:0] start_slot;

    // Link checks
    logic nx_ok;
    logic pv_ok;
    logic ah_ok;
    logic aux_ok;

    // Memory write ports
    logic          next_we;
    logic [IW-1:0] next_wa;
    logic [LW-1:0] next_wd;
    logic          prev_we;
    logic [IW-1:0] prev_wa;
    logic [LW-1:0] prev_wd;

    // Decode the incoming request
    assign is_free    = (operation == spfl_pkg::OP_FREE);
    assign free_avail = (free_head_reg < NULL_LINK);
    assign bump_avail = (used_count_reg < NULL_LINK);
    assign idx_ok     = (CW'(slot_index) < CW'(used_count_reg));
    assign start_go   = is_free ? idx_ok : (free_avail || bump_avail);
    assign start_slot = is_free ? IW'(slot_index)
                      : (free_avail ? IW'(free_head_reg) : IW'(used_count_reg));

    assign nx_ok  = (next_rd_reg < NULL_LINK);
    assign pv_ok  = (prev_rd_reg < NULL_LINK);
    assign ah_ok  = (active_head_reg < NULL_LINK);
    assign aux_ok = (aux_reg < NULL_LINK);

    assign flags.no_work = !go_reg;
    assign handle        = handle_reg;
    assign status        = status_reg;

    // Select link writes for the current phase
    always_comb
    begin
        next_we = 1'b0;
        next_wa = slot_reg;
        next_wd = active_head_reg;
        prev_we = 1'b0;
        prev_wa = slot_reg;
        prev_wd = NULL_LINK;
        if (cmd.link && go_reg)
        begin
            if (!op_reg)
            begin
                // New slot goes to the in-use head
                next_we = 1'b1;
                next_wa = slot_reg;
                next_wd = ah_ok ? active_head_reg : NULL_LINK;
                prev_we = 1'b1;
                prev_wa = slot_reg;
                prev_wd = NULL_LINK;
            end
            else
            begin
                // Unlink the slot from its neighbors
                prev_we = nx_ok;
                prev_wa = IW'(next_rd_reg);
                prev_wd = prev_rd_reg;
                next_we = pv_ok;
                next_wa = IW'(prev_rd_reg);
                next_wd = next_rd_reg;
            end
        end
        else if (cmd.finish && go_reg)
        begin
            if (!op_reg)
            begin
                // Old in-use head points back to the new slot
                prev_we = aux_ok;
                prev_wa = IW'(aux_reg);
                prev_wd = LW'(slot_reg);
            end
            else
            begin
                // Push the freed slot onto the free list
                next_we = 1'b1;
                next_wa = slot_reg;
                next_wd = aux_reg;
            end
        end
    end

    // Link memories: one write each, one registered read at capture
    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (cmd.start)
        begin
            next_rd_reg <= next_mem[start_slot];
            prev_rd_reg <= prev_mem[start_slot];
        end
    end

    // Capture the request and load the result
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg        <= is_free;
            slot_reg      <= start_slot;
            go_reg        <= start_go;
            from_free_reg <= !is_free && free_avail;
            full_reg      <= !is_free && !start_go;
        end
        if (cmd.link && go_reg)
        begin
            aux_reg <= op_reg ? free_head_reg : active_head_reg;
        end
        if (cmd.finish)
        begin
            handle_reg <= (go_reg && !op_reg) ? HW'(slot_reg) : '0;
            status_reg <= full_reg ? spfl_pkg::STATUS_FULL : spfl_pkg::STATUS_OK;
        end
    end

    // Advance list heads and bump counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_head_reg <= NULL_LINK;
            free_head_reg   <= NULL_LINK;
            used_count_reg  <= '0;
        end
        else
        begin
            if (cmd.start && !is_free && !free_avail && bump_avail)
            begin
                used_count_reg <= used_count_reg + 1'b1;
            end
            if (cmd.link && go_reg)
            begin
                if (!op_reg)
                begin
                    if (from_free_reg)
                    begin
                        free_head_reg <= next_rd_reg;
                    end
                    active_head_reg <= LW'(slot_reg);
                end
                else
                begin
                    if (!pv_ok)
                    begin
                        active_head_reg <= next_rd_reg;
                    end
                    free_head_reg <= LW'(slot_reg);
                end
            end
        end
    end

    // Bump counter never passes the pool size
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg <= NULL_LINK)
        else $error("bump counter beyond pool size");

    // Allocate with both sources empty reports full
    a_full_detect: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start && !is_free && !free_avail && !bump_avail |=> full_reg)
        else $error("exhausted pool not reported full");

    // Free never moves the bump counter
    a_free_no_bump: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start && is_free |=> $stable(used_count_reg))
        else $error("bump counter moved on free");

endmodule

// ----- sv/slot_pool_free_list_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_pool_free_list_allocator_core: slot pool allocator top level
// Free list plus doubly linked in-use list over a fixed pool of slots.
// ----------------------------------------------------------------------------
// Each request allocates a slot (from the free list head, else from a bump
// counter of never-used slots) or frees the given slot, and yields exactly one
// result. A request that updates links goes through capture, which reads both
// link memories, a link phase that does the first pair of writes, and finish,
// which does the last write and loads the result register once that register
// holds no untaken result. A full allocate or an ignored free skips the link
// phase. The single write port of each link memory splits the writes between
// link and finish. One request is in flight at a time; the next is accepted
// once the current result is loaded, even while that result still waits to be
// taken. Link memories are not cleared after reset.
// ----------------------------------------------------------------------------
module slot_pool_free_list_allocator_core #(
    parameter int CAPACITY = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    spfl_req_if.sink   req,
    spfl_rsp_if.source rsp
);

    spfl_pkg::cmd_t   cmd;
    spfl_pkg::flags_t flags;

    // Sequence requests
    spfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .flags     (flags),
        .cmd       (cmd)
    );

    // Hold lists and links
    spfl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .flags      (flags),
        .operation  (req.operation),
        .slot_index (req.slot_index),
        .handle     (rsp.handle),
        .status     (rsp.status)
    );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the slot pool allocator core
// Drives allocate and free requests over the request channel and predicts each
// result with a local model of the free list, the in-use list and the bump
// counter. Results are checked in order, field by field. Both channels idle at
// random, and the result side holds off for a long stretch once.
// ----------------------------------------------------------------------------
module testbench;

    localparam int         POOL         = 64;
    localparam logic [6:0] NULL_SLOT    = 7'd64;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         RANDOM_ITEMS = 600;

    typedef struct packed {
        logic [spfl_pkg::HANDLE_W-1:0] handle;
        logic [spfl_pkg::STATUS_W-1:0] status;
    } slot_result_t;

    logic clk;
    logic rst_n;

    spfl_req_if req_ch ();
    spfl_rsp_if rsp_ch ();

    slot_pool_free_list_allocator_core #(
        .CAPACITY (POOL)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Local copy of the pool state
    logic [6:0] next_lnk [POOL];
    logic [6:0] prev_lnk [POOL];
    logic [6:0] active_head;
    logic [6:0] free_head;
    logic [6:0] used_count;

    // Slots believed in use, only for choosing stimulus
    bit in_use [POOL];
    int active_cnt;

    slot_result_t pending_results [$];
    slot_result_t want;
    int           error_count;
    int           cycle_count;
    bit           quiet;
    int           hold_off;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Idle length: mostly none or short, a few long
    function automatic int idle_length();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Apply one request to the local pool state and return its result
    function automatic slot_result_t apply_request(
        input logic [spfl_pkg::OP_W-1:0]   op,
        input logic [spfl_pkg::SLOT_W-1:0] idx);
        slot_result_t res;
        logic [6:0]   slot;
        logic [6:0]   nx;
        logic [6:0]   pv;
        res.handle = '0;
        res.status = spfl_pkg::STATUS_OK;
        if (op == spfl_pkg::OP_ALLOC)
        begin
            if (free_head < NULL_SLOT)
            begin
                slot      = free_head;
                free_head = next_lnk[slot[5:0]];
            end
            else if (used_count < NULL_SLOT)
            begin
                slot       = used_count;
                used_count = used_count + 7'd1;
            end
            else
            begin
                res.status = spfl_pkg::STATUS_FULL;
                return res;
            end
            // link the new slot at the head of the in-use list
            prev_lnk[slot[5:0]] = NULL_SLOT;
            if (active_head < NULL_SLOT)
            begin
                prev_lnk[active_head[5:0]] = slot;
                next_lnk[slot[5:0]]        = active_head;
            end
            else
                next_lnk[slot[5:0]] = NULL_SLOT;
            active_head = slot;
            res.handle  = slot[5:0];
        end
        else if ({1'b0, idx} < used_count)
        begin
            // unlink from the in-use list, push onto the free list
            nx = next_lnk[idx];
            pv = prev_lnk[idx];
            if (nx < NULL_SLOT)
                prev_lnk[nx[5:0]] = pv;
            if (pv < NULL_SLOT)
                next_lnk[pv[5:0]] = nx;
            else
                active_head = nx;
            next_lnk[idx] = free_head;
            free_head     = {1'b0, idx};
        end
        return res;
    endfunction

    // Send one request, then predict its result once accepted
    task automatic send_request(input logic [spfl_pkg::OP_W-1:0]   op,
                                input logic [spfl_pkg::SLOT_W-1:0] idx);
        int           gap;
        slot_result_t res;
        gap = idle_length();
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.slot_index <= idx;
        do @(posedge clk); while (!req_ch.ready);
        res = apply_request(op, idx);
        pending_results.push_back(res);
        if (op == spfl_pkg::OP_ALLOC && res.status == spfl_pkg::STATUS_OK
            && !in_use[res.handle])
        begin
            in_use[res.handle] = 1'b1;
            active_cnt++;
        end
        else if (op == spfl_pkg::OP_FREE && in_use[idx])
        begin
            in_use[idx] = 1'b0;
            active_cnt--;
        end
    endtask

    // Well-formed request: allocate, or free a slot in use
    task automatic send_pool_request(input int alloc_pct);
        int slots [$];
        if (active_cnt == 0 || $urandom_range(0, 99) < alloc_pct)
            send_request(spfl_pkg::OP_ALLOC, spfl_pkg::SLOT_W'($urandom));
        else
        begin
            foreach (in_use[i])
                if (in_use[i])
                    slots.push_back(i);
            send_request(spfl_pkg::OP_FREE,
                         spfl_pkg::SLOT_W'(slots[$urandom_range(0, slots.size() - 1)]));
        end
    endtask

    // Hold the sender until every expected result is in
    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Extremes, ignored frees, unlinking head, middle and tail, free list reuse
    task automatic test_directed();
        send_request(spfl_pkg::OP_ALLOC, 6'd0);
        send_request(spfl_pkg::OP_ALLOC, 6'd63);
        send_request(spfl_pkg::OP_ALLOC, 6'd21);
        send_request(spfl_pkg::OP_ALLOC, 6'd42);
        send_request(spfl_pkg::OP_FREE, 6'd63);
        send_request(spfl_pkg::OP_FREE, 6'd4);
        send_request(spfl_pkg::OP_FREE, 6'd2);
        send_request(spfl_pkg::OP_FREE, 6'd3);
        send_request(spfl_pkg::OP_FREE, 6'd0);
        send_request(spfl_pkg::OP_ALLOC, 6'd63);
        send_request(spfl_pkg::OP_ALLOC, 6'd0);
        send_request(spfl_pkg::OP_ALLOC, 6'd63);
        send_request(spfl_pkg::OP_ALLOC, 6'd0);
        send_request(spfl_pkg::OP_FREE, 6'd5);
        send_request(spfl_pkg::OP_FREE, 6'd4);
        send_request(spfl_pkg::OP_FREE, 6'd1);
        send_request(spfl_pkg::OP_ALLOC, 6'd63);
        send_request(spfl_pkg::OP_ALLOC, 6'd0);
        wait_drained();
    endtask

    // Exhaust the pool back to back, hit full, then recycle
    task automatic test_pool_full();
        quiet = 1'b1;
        while (active_cnt < POOL)
            send_request(spfl_pkg::OP_ALLOC, spfl_pkg::SLOT_W'($urandom));
        send_request(spfl_pkg::OP_ALLOC, 6'd63);
        send_request(spfl_pkg::OP_ALLOC, 6'd0);
        quiet = 1'b0;
        send_request(spfl_pkg::OP_FREE, 6'd63);
        send_request(spfl_pkg::OP_FREE, 6'd0);
        send_request(spfl_pkg::OP_ALLOC, 6'd0);
        send_request(spfl_pkg::OP_ALLOC, 6'd63);
        send_request(spfl_pkg::OP_ALLOC, 6'd0);
        wait_drained();
    endtask

    // Alternate fill and drain phases with random slots
    task automatic test_random_traffic();
        int bias;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
            begin
                bias  = ((n / 50) % 2 == 0) ? 75 : 25;
                quiet = ($urandom_range(0, 3) == 0);
            end
            send_pool_request(bias);
        end
        quiet = 1'b0;
        wait_drained();
    endtask

    // Long result stall while requests keep coming
    task automatic test_result_stall();
        quiet    = 1'b1;
        hold_off = 300;
        repeat (30) send_pool_request(50);
        quiet = 1'b0;
        wait_drained();
    endtask

    // Frees of slots not in use; the lists may end up corrupted, so run last
    task automatic test_unchecked_free();
        repeat (40)
        begin
            if ($urandom_range(0, 99) < 60)
                send_request(spfl_pkg::OP_FREE, spfl_pkg::SLOT_W'($urandom));
            else
                send_request(spfl_pkg::OP_ALLOC, spfl_pkg::SLOT_W'($urandom));
        end
        wait_drained();
    endtask

    // Result receiver: random stalls, plus a long hold when asked
    initial
    begin
        int stall;
        stall        = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                stall    = hold_off;
                hold_off = 0;
            end
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                stall = idle_length();
            end
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result handle %0d status %0d", $time,
                         rsp_ch.handle, rsp_ch.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.handle !== want.handle)
                begin
                    error_count++;
                    $display("%0t: handle expected %0d actual %0d", $time,
                             want.handle, rsp_ch.handle);
                end
                if (rsp_ch.status !== want.status)
                begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, rsp_ch.status);
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        error_count       = 0;
        cycle_count       = 0;
        quiet             = 1'b0;
        hold_off          = 0;
        active_cnt        = 0;
        active_head       = NULL_SLOT;
        free_head         = NULL_SLOT;
        used_count        = '0;
        foreach (next_lnk[i])
        begin
            next_lnk[i] = '0;
            prev_lnk[i] = '0;
            in_use[i]   = 1'b0;
        end
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.operation  = spfl_pkg::OP_ALLOC;
        req_ch.slot_index = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_pool_full();
        test_random_traffic();
        test_result_stall();
        test_unchecked_free();

        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- slot_pool_free_list_allocator_core.f -----
sv/spfl_pkg.sv
sv/spfl_if.sv
sv/spfl_ctrl.sv
sv/spfl_datapath.sv
sv/slot_pool_free_list_allocator_core.sv
test/testbench.sv
